### rtl/csim_pkg.sv
// Package for the cosine similarity engine.
// Holds the field widths, derived sizes and the shared accumulator-sum record.
// No dependencies.
package csim_pkg;

    localparam int ELEM_W   = 16;                 // element width, Q4.12
    localparam int PROD_W   = 2 * ELEM_W;         // one element product
    localparam int ACC_W    = 48;                 // accumulator width
    localparam int ROOT_W   = ACC_W / 2;          // floor root of an accumulator
    localparam int SIM_W    = 16;                 // result width, Q1.15
    localparam int FRAC_W   = SIM_W - 1;          // fraction bits of the result
    localparam int Q_W      = SIM_W;              // quotient bits worked out by the divider
    localparam int DIV_W    = ACC_W + FRAC_W;     // dividend and shifted divisor width
    localparam int ROOT_CW  = $clog2(ROOT_W);
    localparam int Q_CW     = $clog2(Q_W);
    localparam int QDEPTH   = 2;                  // finished-vector queue depth
    localparam int QPTR_W   = $clog2(QDEPTH);

    // Totals of one vector pair, handed from the front to the back.
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
    } csim_sums_t;

endpackage

### rtl/csim_pair_if.sv
// Input channel of the cosine similarity engine: one element pair per transfer.
// Depends on csim_pkg.
interface csim_pair_if
    import csim_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last_pair;

    modport source (output valid, output a_elem, output b_elem, output last_pair,
                    input ready);
    modport sink   (input valid, input a_elem, input b_elem, input last_pair,
                    output ready);
endinterface

### rtl/csim_result_if.sv
// Output channel of the cosine similarity engine: one similarity per transfer.
// Depends on csim_pkg.
interface csim_result_if
    import csim_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;

    modport source (output valid, output similarity, output zero_norm, input ready);
    modport sink   (input valid, input similarity, input zero_norm, output ready);
endinterface

### rtl/csim_front.sv
// Front end: accepts element pairs, accumulates dot product and squared norms
// with saturation, and pushes the totals on the last pair. Depends on csim_pkg.
module csim_front
    import csim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ELEM_W-1:0] a_elem,
    input  logic signed [ELEM_W-1:0] b_elem,
    input  logic                     last_pair,
    input  logic                     q_full,
    output logic                     push,
    output csim_sums_t               push_sums
);

    localparam logic signed [ACC_W:0] DOT_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] DOT_MIN = {2'b11, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0]  dot_reg, dot_next;
    logic [ACC_W-1:0]         na_reg, na_next;
    logic [ACC_W-1:0]         nb_reg, nb_next;
    logic signed [PROD_W-1:0] ab, aa, bb;
    logic signed [ACC_W:0]    dot_sum;
    logic [ACC_W:0]           na_sum, nb_sum;
    logic                     accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ab = a_elem * b_elem;
        aa = a_elem * a_elem;
        bb = b_elem * b_elem;

        dot_sum = {dot_reg[ACC_W-1], dot_reg}
                + {{(ACC_W+1-PROD_W){ab[PROD_W-1]}}, ab};
        // squares are never negative
        na_sum  = {1'b0, na_reg} + {{(ACC_W+1-PROD_W){1'b0}}, aa};
        nb_sum  = {1'b0, nb_reg} + {{(ACC_W+1-PROD_W){1'b0}}, bb};

        if (dot_sum > DOT_MAX)
        begin
            dot_next = DOT_MAX[ACC_W-1:0];
        end
        else if (dot_sum < DOT_MIN)
        begin
            dot_next = DOT_MIN[ACC_W-1:0];
        end
        else
        begin
            dot_next = dot_sum[ACC_W-1:0];
        end
        na_next = na_sum[ACC_W] ? {ACC_W{1'b1}} : na_sum[ACC_W-1:0];
        nb_next = nb_sum[ACC_W] ? {ACC_W{1'b1}} : nb_sum[ACC_W-1:0];
    end

    assign push             = accept && last_pair;
    assign push_sums.dot    = dot_next;
    assign push_sums.norm_a = na_next;
    assign push_sums.norm_b = nb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_pair)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end

endmodule

### rtl/csim_queue.sv
// Short queue of finished vector totals between front and back.
// Depends on csim_pkg.
module csim_queue
    import csim_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  csim_sums_t push_sums,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output csim_sums_t head
);

    csim_sums_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == QDEPTH[QPTR_W:0]);
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_sums;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/csim_sqrt.sv
// Floor square root of an accumulator value, one result bit per cycle.
// Depends on csim_pkg.
module csim_sqrt
    import csim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [ACC_W-1:0]   x_reg, root_reg, bit_reg, trial;
    logic [ROOT_CW-1:0] cnt_reg;
    logic               busy_reg, done_reg;

    assign trial = root_reg + bit_reg;
    assign done  = done_reg;
    assign root  = root_reg[ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= value;
            root_reg <= '0;
            bit_reg  <= {2'b01, {(ACC_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg    <= x_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CW'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/csim_back.sv
// Back end: takes vector totals from the queue, runs both roots, the root
// product and a restoring divide, saturates and holds the result; a zero
// norm instead gives 0 with zero_norm set. Depends on csim_pkg and csim_sqrt.
module csim_back
    import csim_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  csim_sums_t              q_head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SIM_W-1:0] similarity,
    output logic                    zero_norm
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ROOT  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_HOLD  = 7'b1000000
    } state_t;

    localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

    state_t                  state_reg;
    logic                    neg_reg, sat_reg, zero_reg, valid_reg;
    logic [ACC_W-1:0]        mag_reg, prod_reg;
    logic [DIV_W-1:0]        rem_reg, div_reg;
    logic [Q_W-1:0]          q_reg;
    logic [Q_CW-1:0]         cnt_reg;
    logic signed [SIM_W-1:0] sim_reg;
    logic                    start, done_a, done_b;
    logic [ROOT_W-1:0]       root_a, root_b;
    logic                    head_zero;
    logic signed [ACC_W-1:0] dot_neg;
    logic [Q_W-1:0]          q_neg;

    assign head_zero = (q_head.norm_a == '0) || (q_head.norm_b == '0);
    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign start     = pop && !head_zero;
    assign dot_neg   = -q_head.dot;
    assign q_neg     = ~q_reg + 1'b1;

    csim_sqrt u_sqrt_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (q_head.norm_a),
        .done  (done_a),
        .root  (root_a)
    );

    csim_sqrt u_sqrt_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (q_head.norm_b),
        .done  (done_b),
        .root  (root_b)
    );

    assign out_valid  = valid_reg;
    assign similarity = sim_reg;
    assign zero_norm  = zero_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                neg_reg <= q_head.dot[ACC_W-1];
                mag_reg <= q_head.dot[ACC_W-1] ? dot_neg : q_head.dot;
            end
            S_MUL:
            begin
                prod_reg <= root_a * root_b;
            end
            S_CHECK:
            begin
                // quotient of 2^16 or more always saturates
                sat_reg <= ({1'b0, mag_reg} >= {prod_reg, 1'b0});
                rem_reg <= {mag_reg, {FRAC_W{1'b0}}};
                div_reg <= {prod_reg, {FRAC_W{1'b0}}};
                q_reg   <= '0;
                cnt_reg <= Q_CW'(Q_W - 1);
            end
            S_DIV:
            begin
                if (rem_reg >= div_reg)
                begin
                    rem_reg <= rem_reg - div_reg;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[Q_W-2:0], 1'b0};
                end
                div_reg <= div_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            S_ROOT, S_FIN, S_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            sim_reg   <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (head_zero)
                        begin
                            sim_reg   <= '0;
                            zero_reg  <= 1'b1;
                            valid_reg <= 1'b1;
                            state_reg <= S_HOLD;
                        end
                        else
                        begin
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_ROOT:
                begin
                    if (done_a && done_b)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (sat_reg || cnt_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (neg_reg)
                    begin
                        sim_reg <= (sat_reg || q_reg > NEG_LIMIT) ? NEG_LIMIT : q_neg;
                    end
                    else
                    begin
                        sim_reg <= (sat_reg || q_reg > POS_LIMIT) ? POS_LIMIT : q_reg;
                    end
                    zero_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (out_ready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/cosine_similarity_engine.sv
// Cosine similarity engine, top level: front accumulator, totals queue, back end.
// Depends on csim_pkg, csim_pair_if, csim_result_if, csim_front, csim_queue,
// csim_back.
//
// Streams element pairs (signed Q4.12) and gives one Q1.15 cosine similarity per
// vector, on the pair marked last_pair. The front takes one pair per cycle; its
// only stall is when the two-entry queue of finished vector totals is full. The
// back handles one vector at a time: two bit-serial square roots run side by
// side, then the root product, one range check and a restoring divide of 16
// quotient bits (one quotient bit per cycle), cut short when the quotient is
// known to saturate. A vector with a zero norm gives 0 with zero_norm set,
// without the roots or the divide. The result sits in an output register until
// taken.
module cosine_similarity_engine
    import csim_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    csim_pair_if.sink     pairs,
    csim_result_if.source result
);

    logic       q_full, push, pop, q_valid;
    csim_sums_t push_sums, q_head;

    csim_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pairs.valid),
        .in_ready  (pairs.ready),
        .a_elem    (pairs.a_elem),
        .b_elem    (pairs.b_elem),
        .last_pair (pairs.last_pair),
        .q_full    (q_full),
        .push      (push),
        .push_sums (push_sums)
    );

    csim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_sums (push_sums),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    csim_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .similarity (result.similarity),
        .zero_norm  (result.zero_norm)
    );

endmodule
